@@ rtl/four_channel_led_fade_controller_core_macros.svh @@
// assertion macros for the four channel led fade controller core
`ifndef FOUR_CHANNEL_LED_FADE_CONTROLLER_CORE_MACROS_SVH
`define FOUR_CHANNEL_LED_FADE_CONTROLLER_CORE_MACROS_SVH

// condition holds at every clock edge outside reset
`define LEDFC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LEDFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ledfc_pkg.sv @@
// shared constants, types and helpers of the led fade controller
package ledfc_pkg;

    // level width of every channel
    localparam int LEVEL_BITS = 16;
    localparam int NUM_CHANNELS = 4;
    localparam int CH_WARM = 0;

    // warm level squared
    localparam int SQ_BITS = 2 * LEVEL_BITS;

    // floor(x / 1000) as floor((x >> 3) / 125), exact for a 32-bit square
    localparam int RECIP_BITS = 30;
    localparam logic [RECIP_BITS-1:0] RECIP_125 = 30'd549755814;
    localparam int RECIP_SHIFT = 36;
    localparam logic [15:0] RATE_OFFSET = 16'd200;

    // divide by five through a reciprocal, exact over the level range
    localparam int DIV5_SHIFT = LEVEL_BITS + 2;
    localparam logic [LEVEL_BITS:0] DIV5_MULT = (LEVEL_BITS + 1)'(((2 ** DIV5_SHIFT) + 4) / 5);

    // command codes
    localparam logic [3:0] CMD_TICK        = 4'd0;
    localparam logic [3:0] CMD_PERIOD      = 4'd1;
    localparam logic [3:0] CMD_CYCLE_MODE  = 4'd2;
    localparam logic [3:0] CMD_SET_WARM    = 4'd3;
    localparam logic [3:0] CMD_SET_RGB     = 4'd4;
    localparam logic [3:0] CMD_WARM_OFF    = 4'd5;
    localparam logic [3:0] CMD_ALL_OFF     = 4'd6;
    localparam logic [3:0] CMD_ENTER_SETUP = 4'd7;
    localparam logic [3:0] CMD_EXIT_SETUP  = 4'd8;
    localparam logic [3:0] CMD_FLASH       = 4'd9;

    // light modes
    localparam logic [2:0] MODE_SLEEP  = 3'd0;
    localparam logic [2:0] MODE_M0     = 3'd1;
    localparam logic [2:0] MODE_M1     = 3'd2;
    localparam logic [2:0] MODE_BREATH = 3'd3;
    localparam logic [2:0] MODE_SETUP  = 3'd4;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_BRIGHTNESS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_BRIGHTNESS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_RATE   = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] MAX_BRIGHTNESS_RESET = 16'd1000;
    localparam logic [15:0] MIN_BRIGHTNESS_RESET = 16'd10;
    localparam logic [15:0] DEFAULT_RATE_RESET   = 16'd1000;

    // per-channel update request
    typedef struct packed {
        logic                  step;
        logic                  load_tgt;
        logic [LEVEL_BITS-1:0] tgt_val;
        logic                  clr_cur;
        logic                  load_drv;
        logic [LEVEL_BITS-1:0] drv_val;
    } chan_ctl_t;

    // per-channel levels, present and next
    typedef struct packed {
        logic [LEVEL_BITS-1:0] cur;
        logic [LEVEL_BITS-1:0] tgt;
        logic [LEVEL_BITS-1:0] cur_next;
        logic [LEVEL_BITS-1:0] drv_next;
    } chan_stat_t;

    function automatic logic [LEVEL_BITS-1:0] div5(input logic [LEVEL_BITS-1:0] x);
        logic [2*LEVEL_BITS:0] prod;
        prod = x * DIV5_MULT;
        return LEVEL_BITS'(prod >> DIV5_SHIFT);
    endfunction

endpackage

@@ rtl/four_channel_led_fade_controller_core.sv @@
// top level of the four channel led fade controller
// Takes one command item per cycle on the s_ stream while s_tready is high and returns one
// result item per command on the m_ stream: the item passes an input register, then one
// pass of update logic writes the channel levels, mode, tick rate and the result register
// together. With m_tready held high an item is taken every cycle; while a result waits the
// input register takes one more item and then holds s_tready low. The period command's rate
// comes from a registered square of the warm level, kept current on every level change, times
// a reciprocal of 1000 plus 200, or is the default rate when the new warm target is zero.
// Configuration writes are taken at any time (cfg_ready is always high) and are meant for
// idle periods. No clearing pass follows reset.
module four_channel_led_fade_controller_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // value_a[15:0], value_b[31:16], value_c[47:32]
    input  logic [3:0]  s_tuser,   // command[3:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // warm_drive[15:0], red_drive[31:16], green_drive[47:32], blue_drive[63:48],
    // tick_rate[79:64], light_mode_out[82:80], zero fill[87:83]
    output logic [87:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ledfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    `include "four_channel_led_fade_controller_core_macros.svh"

    localparam int L = ledfc_pkg::LEVEL_BITS;
    localparam int NCH = ledfc_pkg::NUM_CHANNELS;
    localparam int W = ledfc_pkg::CH_WARM;

    // configuration registers
    logic [15:0]  max_reg, min_reg, def_rate_reg;
    logic [L-1:0] max_div5_reg;

    // input register
    logic         in_valid_reg, in_valid_next;
    logic [3:0]   in_cmd_reg;
    logic [L-1:0] in_a_reg, in_b_reg, in_c_reg;

    // result register
    logic         out_valid_reg, out_valid_next;
    logic [87:0]  out_data_reg, out_data_next;

    // block state
    logic [2:0]   mode_reg, mode_next;
    logic [2:0]   saved_reg, saved_next;
    logic [15:0]  rate_reg, rate_next;
    logic         flash_reg, flash_next;
    logic [ledfc_pkg::SQ_BITS-1:0] sq_reg, sq_next;

    ledfc_pkg::chan_ctl_t  ctl [NCH];
    ledfc_pkg::chan_stat_t stat [NCH];

    logic advance;
    logic [L-1:0] maxl, minl, max_half;
    logic [3:0]   mode_inc;
    logic [2:0]   mode_cycled;
    logic [L-1:0] warm_tgt_new;
    logic [ledfc_pkg::SQ_BITS-4:0] sq_div8;
    logic [ledfc_pkg::SQ_BITS-4+ledfc_pkg::RECIP_BITS:0] rate_prod;
    logic [15:0]  rate_calc;
    logic [ledfc_pkg::SQ_BITS-1:0] sq_check;

    // handshake and flow through the two registers
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;
    assign cfg_ready      = 1'b1;
    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // level views of the configuration
    assign maxl     = max_reg[L-1:0];
    assign minl     = min_reg[L-1:0];
    assign max_half = maxl >> 1;

    // rate from the registered warm square
    assign sq_div8   = sq_reg[ledfc_pkg::SQ_BITS-1:3];
    assign rate_prod = sq_div8 * ledfc_pkg::RECIP_125;
    assign rate_calc = 16'(rate_prod >> ledfc_pkg::RECIP_SHIFT) + ledfc_pkg::RATE_OFFSET;

    // next mode when cycling
    assign mode_inc    = {1'b0, mode_reg} + 4'd1;
    assign mode_cycled = (mode_inc >= {1'b0, ledfc_pkg::MODE_SETUP}) ?
                         ledfc_pkg::MODE_SLEEP : mode_inc[2:0];

    // breathing toggle of the warm target
    always_comb begin
        warm_tgt_new = stat[W].tgt;
        if (mode_reg == ledfc_pkg::MODE_BREATH && stat[W].cur == stat[W].tgt) begin
            warm_tgt_new = (stat[W].tgt == maxl) ? '0 : maxl;
        end
    end

    // command decode
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            ctl[i] = '0;
        end
        mode_next  = mode_reg;
        saved_next = saved_reg;
        rate_next  = rate_reg;
        flash_next = flash_reg;
        if (advance) begin
            case (in_cmd_reg)
                ledfc_pkg::CMD_TICK: begin
                    if (mode_reg != ledfc_pkg::MODE_SETUP) begin
                        for (int i = 0; i < NCH; i++) begin
                            ctl[i].step = 1'b1;
                        end
                    end
                end
                ledfc_pkg::CMD_PERIOD: begin
                    ctl[W].load_tgt = 1'b1;
                    ctl[W].tgt_val  = warm_tgt_new;
                    rate_next = (warm_tgt_new != '0) ? rate_calc : def_rate_reg;
                end
                ledfc_pkg::CMD_CYCLE_MODE: begin
                    mode_next = mode_cycled;
                    if (mode_cycled != ledfc_pkg::MODE_BREATH) begin
                        for (int i = 0; i < NCH; i++) begin
                            ctl[i].load_tgt = 1'b1;
                        end
                        if (mode_cycled == ledfc_pkg::MODE_M0) begin
                            ctl[W].tgt_val = max_div5_reg;
                        end else if (mode_cycled == ledfc_pkg::MODE_M1) begin
                            ctl[W].tgt_val = maxl;
                        end
                    end
                end
                ledfc_pkg::CMD_SET_WARM: begin
                    for (int i = 0; i < NCH; i++) begin
                        ctl[i].load_tgt = 1'b1;
                    end
                    ctl[W].tgt_val = (in_a_reg < minl) ? minl : in_a_reg;
                end
                ledfc_pkg::CMD_SET_RGB: begin
                    for (int i = 0; i < NCH; i++) begin
                        ctl[i].load_tgt = 1'b1;
                    end
                    if (in_a_reg == '0 && in_b_reg == '0 && in_c_reg == '0) begin
                        ctl[1].tgt_val = minl;
                        ctl[2].tgt_val = minl;
                        ctl[3].tgt_val = minl;
                    end else begin
                        ctl[1].tgt_val = in_a_reg;
                        ctl[2].tgt_val = in_b_reg;
                        ctl[3].tgt_val = in_c_reg;
                    end
                end
                ledfc_pkg::CMD_WARM_OFF: begin
                    ctl[W].load_tgt = 1'b1;
                end
                ledfc_pkg::CMD_ALL_OFF: begin
                    for (int i = 0; i < NCH; i++) begin
                        ctl[i].load_tgt = 1'b1;
                    end
                    mode_next = ledfc_pkg::MODE_SLEEP;
                end
                ledfc_pkg::CMD_ENTER_SETUP: begin
                    saved_next = mode_reg;
                    mode_next  = ledfc_pkg::MODE_SETUP;
                    for (int i = 0; i < NCH; i++) begin
                        ctl[i].load_drv = 1'b1;
                    end
                end
                ledfc_pkg::CMD_EXIT_SETUP: begin
                    mode_next = saved_reg;
                    for (int i = 0; i < NCH; i++) begin
                        ctl[i].load_drv = 1'b1;
                        ctl[i].clr_cur  = 1'b1;
                    end
                end
                ledfc_pkg::CMD_FLASH: begin
                    ctl[W].load_drv = 1'b1;
                    ctl[W].drv_val  = flash_reg ? max_half : '0;
                    flash_next      = !flash_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // fade channels: warm, red, green, blue
    for (genvar g = 0; g < NCH; g++) begin : g_chan
        ledfc_chan u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl[g]),
            .stat    (stat[g])
        );
    end

    // square of the warm level, tracked alongside it
    assign sq_next = stat[W].cur_next * stat[W].cur_next;

    // result item built from the updated state
    always_comb begin
        out_data_next = out_data_reg;
        if (advance) begin
            out_data_next = {5'd0, mode_next, rate_next,
                             16'(stat[3].drv_next), 16'(stat[2].drv_next),
                             16'(stat[1].drv_next), 16'(stat[0].drv_next)};
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= ledfc_pkg::MODE_SLEEP;
            saved_reg     <= ledfc_pkg::MODE_SLEEP;
            rate_reg      <= ledfc_pkg::DEFAULT_RATE_RESET;
            flash_reg     <= 1'b1;
            sq_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            saved_reg     <= saved_next;
            rate_reg      <= rate_next;
            flash_reg     <= flash_next;
            sq_reg        <= sq_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg      <= ledfc_pkg::MAX_BRIGHTNESS_RESET;
            min_reg      <= ledfc_pkg::MIN_BRIGHTNESS_RESET;
            def_rate_reg <= ledfc_pkg::DEFAULT_RATE_RESET;
            max_div5_reg <= ledfc_pkg::div5(ledfc_pkg::MAX_BRIGHTNESS_RESET[L-1:0]);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ledfc_pkg::REG_MAX_BRIGHTNESS: begin
                    max_reg      <= cfg_data;
                    max_div5_reg <= ledfc_pkg::div5(cfg_data[L-1:0]);
                end
                ledfc_pkg::REG_MIN_BRIGHTNESS: begin
                    min_reg <= cfg_data;
                end
                ledfc_pkg::REG_DEFAULT_RATE: begin
                    def_rate_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // input payload register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_tuser;
            in_a_reg   <= s_tdata[L-1:0];
            in_b_reg   <= s_tdata[16+L-1:16];
            in_c_reg   <= s_tdata[32+L-1:32];
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    // checks
    assign sq_check = stat[W].cur * stat[W].cur;

    `LEDFC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg, "item lost between stages")
    `LEDFC_ASSERT_ALWAYS(a_square_tracks_warm, sq_reg == sq_check, "warm square out of step")
    `LEDFC_ASSERT_NEXT(a_exit_clears_levels,
        advance && in_cmd_reg == ledfc_pkg::CMD_EXIT_SETUP,
        stat[0].cur == '0 && stat[1].cur == '0 && stat[2].cur == '0 && stat[3].cur == '0,
        "exit setup left a current level")

endmodule

@@ rtl/ledfc_chan.sv @@
// one fade channel: current, target and drive levels
module ledfc_chan (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ledfc_pkg::chan_ctl_t   ctl,
    output ledfc_pkg::chan_stat_t  stat
);

    logic [ledfc_pkg::LEVEL_BITS-1:0] cur_reg, cur_next;
    logic [ledfc_pkg::LEVEL_BITS-1:0] tgt_reg, tgt_next;
    logic [ledfc_pkg::LEVEL_BITS-1:0] drv_reg, drv_next;

    // fade step toward target, then direct loads
    always_comb begin
        cur_next = cur_reg;
        tgt_next = tgt_reg;
        drv_next = drv_reg;
        if (ctl.step) begin
            if (cur_reg > tgt_reg) begin
                cur_next = cur_reg - 1'b1;
                drv_next = cur_reg - 1'b1;
            end else if (cur_reg < tgt_reg) begin
                cur_next = cur_reg + 1'b1;
                drv_next = cur_reg + 1'b1;
            end
        end
        if (ctl.clr_cur) begin
            cur_next = '0;
        end
        if (ctl.load_drv) begin
            drv_next = ctl.drv_val;
        end
        if (ctl.load_tgt) begin
            tgt_next = ctl.tgt_val;
        end
    end

    // level registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            tgt_reg <= '0;
            drv_reg <= '0;
        end else begin
            cur_reg <= cur_next;
            tgt_reg <= tgt_next;
            drv_reg <= drv_next;
        end
    end

    assign stat.cur      = cur_reg;
    assign stat.tgt      = tgt_reg;
    assign stat.cur_next = cur_next;
    assign stat.drv_next = drv_next;

endmodule
